// File: rtl/hks_pkg.sv
`default_nettype none
package hks_pkg;
    localparam logic [31:0] MUR_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2  = 32'h1b873593;
    localparam logic [31:0] MUR_ADD = 32'he6546b64;
    localparam logic [31:0] MUR_F1  = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2  = 32'hc2b2ae35;
    localparam logic [31:0] KEY_BYTES = 32'd8;

    localparam logic [0:0] ACT_INSERT = 1'b0;
    localparam logic [0:0] ACT_QUERY  = 1'b1;

    localparam logic [0:0] REG_SEED    = 1'b0;
    localparam logic [0:0] REG_BUCKETS = 1'b1;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_MIX,
        HS_FIN,
        HS_MOD,
        HS_PUSH
    } hash_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_READ,
        BK_SCAN,
        BK_WRITE,
        BK_OUT
    } back_state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction
endpackage
`default_nettype wire

// File: rtl/hks_front.sv
`default_nettype none
// Hash unit: one multiply per cycle, then a restoring modulo, one bit per cycle.
module hks_front #(
    parameter int BW = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_action,
    input  wire logic [63:0]   in_key,
    input  wire logic [31:0]   seed,
    input  wire logic [BW:0]   nbuckets,
    output logic               q_valid,
    input  wire logic          q_ready,
    output logic               q_action,
    output logic [63:0]        q_key,
    output logic [BW-1:0]      q_bucket
);
    import hks_pkg::*;

    hash_state_t state_reg, state_next;
    logic [3:0]  step_reg;
    logic [31:0] h_reg;
    logic [31:0] k_reg;
    logic [31:0] mul_a, mul_b, mul_p;
    logic [63:0] key_reg;
    logic        action_reg;
    logic [32:0] rem_reg;
    logic [5:0]  bit_reg;
    logic [BW:0] div_reg;
    logic [32:0] rem_sh;

    assign mul_p = mul_a * mul_b;
    assign rem_sh = {rem_reg[31:0], h_reg[bit_reg[4:0]]};

    // Steps of the mix: 0..3 first block, 4..7 second block; finalization 0..2.
    always_comb
    begin
        mul_a = k_reg;
        mul_b = MUR_C1;
        case (step_reg[1:0])
            2'd1: mul_b = MUR_C2;
            2'd2: mul_b = 32'd5;
            default: mul_b = MUR_C1;
        endcase
        if (state_reg == HS_FIN) begin
            mul_a = k_reg;
            mul_b = (step_reg[0] == 1'b0) ? MUR_F1 : MUR_F2;
        end
        if (state_reg == HS_MIX && step_reg[1:0] == 2'd2)
            mul_a = h_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            HS_IDLE: if (in_valid) state_next = HS_MIX;
            HS_MIX:  if (step_reg == 4'd7) state_next = HS_FIN;
            HS_FIN:  if (step_reg == 4'd2) state_next = HS_MOD;
            HS_MOD:  if (bit_reg == 6'd0) state_next = HS_PUSH;
            HS_PUSH: if (q_ready) state_next = HS_IDLE;
            default: state_next = HS_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == HS_IDLE);
        q_valid  = (state_reg == HS_PUSH);
    end

    assign q_action = action_reg;
    assign q_key    = key_reg;
    assign q_bucket = rem_reg[BW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= HS_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg != state_next)
                step_reg <= '0;
            else
                step_reg <= step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            HS_IDLE:
            begin
                key_reg    <= in_key;
                action_reg <= in_action;
                h_reg      <= seed;
                k_reg      <= in_key[31:0];
                div_reg    <= (nbuckets == '0) ? {{BW{1'b0}}, 1'b1} : nbuckets;
            end
            HS_MIX:
            begin
                case (step_reg[1:0])
                    2'd0: k_reg <= rotl32(mul_p, 15);
                    2'd1: h_reg <= rotl32(h_reg ^ mul_p, 13);
                    2'd2: h_reg <= mul_p + MUR_ADD;
                    default: k_reg <= key_reg[63:32];
                endcase
                if (step_reg == 4'd7) begin
                    h_reg <= h_reg ^ KEY_BYTES ^ ((h_reg ^ KEY_BYTES) >> 16);
                    k_reg <= h_reg ^ KEY_BYTES ^ ((h_reg ^ KEY_BYTES) >> 16);
                end
            end
            HS_FIN:
            begin
                case (step_reg[1:0])
                    2'd0: k_reg <= mul_p ^ (mul_p >> 13);
                    2'd1:
                    begin
                        h_reg <= mul_p ^ (mul_p >> 16);
                        k_reg <= mul_p ^ (mul_p >> 16);
                    end
                    default: ;
                endcase
                rem_reg <= '0;
                bit_reg <= 6'd31;
            end
            HS_MOD:
            begin
                if (rem_sh >= {{(32-BW){1'b0}}, div_reg})
                    rem_reg <= rem_sh - {{(32-BW){1'b0}}, div_reg};
                else
                    rem_reg <= rem_sh;
                bit_reg <= bit_reg - 6'd1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/hks_queue.sv
`default_nettype none
module hks_queue #(
    parameter int BW = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire logic          wr_action,
    input  wire logic [63:0]   wr_key,
    input  wire logic [BW-1:0] wr_bucket,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output logic               rd_action,
    output logic [63:0]        rd_key,
    output logic [BW-1:0]      rd_bucket
);
    logic [1:0]           cnt_reg;
    logic                 wp_reg, rp_reg;
    logic [64+BW:0]       mem_reg [2];
    logic                 do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;
    assign {rd_action, rd_key, rd_bucket} = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= {wr_action, wr_key, wr_bucket};
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_empty_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !do_rd) else $error("read from empty queue");
    a_full_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !do_wr) else $error("write to full queue");
`endif
endmodule
`default_nettype wire

// File: rtl/hks_back.sv
`default_nettype none
// Bucket store: one row of WAYS slots per bucket, read, scanned, and written back when a key is stored.
module hks_back #(
    parameter int NB   = 1024,
    parameter int WAYS = 8,
    parameter int BW   = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire logic          q_action,
    input  wire logic [63:0]   q_key,
    input  wire logic [BW-1:0] q_bucket,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [2:0]         out_data
);
    import hks_pkg::*;

    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    back_state_t state_reg, state_next;
    logic [WAYS-1:0][63:0] key_mem [NB];
    logic [WAYS-1:0]       val_mem [NB];
    logic [WAYS-1:0][63:0] rd_keys_reg;
    logic [WAYS-1:0][63:0] wr_row;
    logic [WAYS-1:0] rd_val_reg;
    logic [BW-1:0]   clr_reg;
    logic [BW-1:0]   bucket_reg;
    logic [63:0]     key_reg;
    logic            action_reg;
    logic            found_reg, stored_reg, full_reg;
    logic [WW-1:0]   free_reg;
    logic            have_free;
    logic [WW-1:0]   free_idx;
    logic            hit;

    always_comb
    begin
        hit = 1'b0;
        have_free = 1'b0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (rd_val_reg[w] && rd_keys_reg[w] == key_reg)
                hit = 1'b1;
            if (!rd_val_reg[w] && !have_free) begin
                have_free = 1'b1;
                free_idx = WW'(w);
            end
        end
    end

    // row written back with the new key in the first free slot
    always_comb
    begin
        wr_row = rd_keys_reg;
        wr_row[free_reg] = key_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR: if (clr_reg == BW'(NB - 1)) state_next = BK_IDLE;
            BK_IDLE:  if (q_valid) state_next = BK_READ;
            BK_READ:  state_next = BK_SCAN;
            BK_SCAN:  state_next = BK_WRITE;
            BK_WRITE: state_next = BK_OUT;
            BK_OUT:   if (out_ready) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready   = (state_reg == BK_IDLE);
        out_valid = (state_reg == BK_OUT);
        out_data  = {full_reg, stored_reg, found_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR)
                clr_reg <= clr_reg + BW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE) begin
            bucket_reg <= q_bucket;
            key_reg    <= q_key;
            action_reg <= q_action;
        end
        if (state_reg == BK_READ) begin
            rd_val_reg  <= val_mem[bucket_reg];
            rd_keys_reg <= key_mem[bucket_reg];
        end
        if (state_reg == BK_SCAN) begin
            found_reg  <= hit;
            stored_reg <= (action_reg == ACT_INSERT) && !hit && have_free;
            full_reg   <= (action_reg == ACT_INSERT) && !hit && !have_free;
            free_reg   <= free_idx;
        end
        if (state_reg == BK_CLEAR)
            val_mem[clr_reg] <= '0;
        else if (state_reg == BK_WRITE && stored_reg) begin
            val_mem[bucket_reg] <= rd_val_reg | (WAYS'(1) << free_reg);
            key_mem[bucket_reg] <= wr_row;
        end
    end

`ifndef NO_ASSERTIONS
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(stored_reg && full_reg) && !(found_reg && (stored_reg || full_reg)))
        else $error("conflicting result flags");
    a_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action_reg == ACT_QUERY |-> !stored_reg && !full_reg)
        else $error("query changed the store");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// File: rtl/hashed_key_set_insert_lookup.sv
// Path from request to result: the hash unit's mix, finalize and bit-serial modulo
// steps and a hand-off, the queue, then the bucket read, scan, write and output states.
// The hash unit takes a new item only when idle, so its bit-serial modulo limits throughput;
// the queue lets the hash of the next item overlap the bucket update.
// Reset: asynchronous, active low; afterward the valid bits are cleared by a
// pass over all NUM_BUCKETS buckets during which no result is produced.
`default_nettype none
module hashed_key_set_insert_lookup #(
    parameter int NUM_BUCKETS = 1024,
    parameter int WAYS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // action, key, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // found, stored, bucket_full, zero pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import hks_pkg::*;

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    logic [31:0] seed_reg;
    logic [10:0] count_reg;
    logic [BW:0] nb_eff;
    logic        f_valid, f_ready, f_action;
    logic [63:0] f_key;
    logic [BW-1:0] f_bucket;
    logic        b_valid, b_ready, b_action;
    logic [63:0] b_key;
    logic [BW-1:0] b_bucket;
    logic [2:0]  res;

    assign pready = 1'b1;
    assign m_tdata = {5'd0, res};

    always_comb
    begin
        if ({{(BW > 11 ? BW - 10 : 1){1'b0}}, count_reg} > NUM_BUCKETS)
            nb_eff = (BW + 1)'(NUM_BUCKETS);
        else
            nb_eff = (BW + 1)'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seed_reg  <= '0;
            count_reg <= 11'd1024;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_SEED)
                seed_reg <= pwdata;
            else if (paddr[2] == REG_BUCKETS)
                count_reg <= pwdata[10:0];
        end
    end

    always_comb
    begin
        if (paddr[1:0] != 2'b00)
            prdata = '0;
        else if (paddr[2] == REG_SEED)
            prdata = seed_reg;
        else
            prdata = {21'd0, count_reg};
    end

    hks_front #(.BW(BW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_action(s_tdata[0]), .in_key(s_tdata[64:1]),
        .seed(seed_reg), .nbuckets(nb_eff),
        .q_valid(f_valid), .q_ready(f_ready),
        .q_action(f_action), .q_key(f_key), .q_bucket(f_bucket)
    );

    hks_queue #(.BW(BW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_action(f_action), .wr_key(f_key), .wr_bucket(f_bucket),
        .rd_valid(b_valid), .rd_ready(b_ready),
        .rd_action(b_action), .rd_key(b_key), .rd_bucket(b_bucket)
    );

    hks_back #(.NB(NUM_BUCKETS), .WAYS(WAYS), .BW(BW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready),
        .q_action(b_action), .q_key(b_key), .q_bucket(b_bucket),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
    );
endmodule
`default_nettype wire
